FILE: hdl/rac_pkg.sv
// ----------------------------------------------------------------------------
// Radix ASCII converter package
// Shared widths, controller/datapath command and status types, and the
// digit-to-ASCII lookup used by the converter.
// ----------------------------------------------------------------------------
package rac_pkg;

  // Number of value bits that take part in the conversion.
  localparam int VALUE_WIDTH   = 32;
  // Fixed widths of the channel fields.
  localparam int VALUE_FIELD_W = 32;
  localparam int RADIX_W       = 6;
  localparam int CHAR_W        = 7;

  localparam int VALUE_USE_W   = (VALUE_WIDTH < VALUE_FIELD_W) ? VALUE_WIDTH : VALUE_FIELD_W;

  // The divider retires this many quotient bits per cycle.
  localparam int BITS_PER_STEP = 8;
  localparam int DIV_STEPS     = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int PAD_W         = DIV_STEPS * BITS_PER_STEP;
  localparam int STEP_W        = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  // Digit store sizing.
  localparam int CNT_W         = $clog2(VALUE_WIDTH + 1);
  localparam int IDX_W         = $clog2(VALUE_WIDTH);
  localparam int REM_W         = RADIX_W + 1;

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] ASCII_ALPHA_BIAS = CHAR_W'(55);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DIVIDE = 3'b010,
    ST_EMIT   = 3'b100
  } rac_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture a new value and radix
    logic div_step;  // run one division step
    logic emit;      // move the next stored digit into the output register
  } rac_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic step_last;  // current step completes a division
    logic conv_done;  // the division in flight produces the final digit
    logic emit_last;  // the read pointer sits on the least significant digit
    logic out_valid;  // the output register holds an untaken digit
  } rac_sts_t;

  // Maps a digit value to its ASCII code; codes past 'Z' read as '0'.
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < RADIX_W'(10)) begin
      c = ASCII_ZERO + CHAR_W'(d);
    end else if (d < RADIX_MAX) begin
      c = ASCII_ALPHA_BIAS + CHAR_W'(d);
    end else begin
      c = ASCII_ZERO;
    end
    return c;
  endfunction

endpackage

FILE: hdl/rac_ifs.sv
// ----------------------------------------------------------------------------
// Radix ASCII converter channel interfaces
// Valid/ready channels for the conversion request and the digit stream.
// ----------------------------------------------------------------------------
interface rac_in_if;
  import rac_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [VALUE_FIELD_W-1:0] value;
  logic [RADIX_W-1:0]       radix;

  modport source (output valid, output value, output radix, input ready);
  modport sink   (input valid, input value, input radix, output ready);
endinterface

interface rac_out_if;
  import rac_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] digit_char;
  logic              last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

FILE: hdl/rac_ctrl.sv
// ----------------------------------------------------------------------------
// Radix ASCII converter controller
// Sequences capture, repeated division and reverse-order digit readout.
// ----------------------------------------------------------------------------
module rac_ctrl
  import rac_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     out_ready_i,
  input  rac_sts_t sts_i,
  output rac_cmd_t cmd_o
);

  rac_state_e state_q, state_d;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    in_ready_o     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.step_last && sts_i.conv_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // A digit moves out only when the output register is free or drains now.
        if (!sts_i.out_valid || out_ready_i) begin
          cmd_o.emit = 1'b1;
          if (sts_i.emit_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hdl/rac_dpath.sv
// ----------------------------------------------------------------------------
// Radix ASCII converter datapath
// Shift-subtract divider, remainder store and registered ASCII output.
// ----------------------------------------------------------------------------
module rac_dpath
  import rac_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rac_cmd_t                 cmd_i,
  input  logic [VALUE_FIELD_W-1:0] value_i,
  input  logic [RADIX_W-1:0]       radix_i,
  input  logic                     out_ready_i,
  output rac_sts_t                 sts_o,
  output logic                     out_valid_o,
  output logic [CHAR_W-1:0]        digit_char_o,
  output logic                     last_digit_o
);

  logic [PAD_W-1:0]   quot_q, quot_next;
  logic [REM_W-1:0]   rem_q, rem_next;
  logic [RADIX_W-1:0] radix_q, radix_sat;
  logic [STEP_W-1:0]  step_cnt_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [IDX_W-1:0]   rd_idx_q;
  logic               out_valid_q;
  logic [CHAR_W-1:0]  digit_char_q;
  logic               last_digit_q;
  logic               step_last;

  logic [RADIX_W-1:0] digit_store [VALUE_WIDTH];

  always_comb begin
    if (radix_i < RADIX_MIN) begin
      radix_sat = RADIX_MIN;
    end else if (radix_i > RADIX_MAX) begin
      radix_sat = RADIX_MAX;
    end else begin
      radix_sat = radix_i;
    end
  end

  // Restoring division, BITS_PER_STEP quotient bits per cycle. The remainder
  // stays below the radix, so each trial fits in REM_W bits.
  always_comb begin
    logic [REM_W-1:0] r;
    logic [PAD_W-1:0] q;
    r = rem_q;
    q = quot_q;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      r = {r[REM_W-2:0], q[PAD_W-1]};
      q = {q[PAD_W-2:0], 1'b0};
      if (r >= {1'b0, radix_q}) begin
        r    = r - {1'b0, radix_q};
        q[0] = 1'b1;
      end
    end
    rem_next  = r;
    quot_next = q;
  end

  assign step_last       = (step_cnt_q == STEP_W'(DIV_STEPS - 1));
  assign sts_o.step_last = step_last;
  assign sts_o.conv_done = (quot_next == '0) || (cnt_q == CNT_W'(VALUE_WIDTH - 1));
  assign sts_o.emit_last = (rd_idx_q == '0);
  assign sts_o.out_valid = out_valid_q;

  // Control counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_cnt_q  <= '0;
      cnt_q       <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        step_cnt_q <= '0;
        cnt_q      <= '0;
      end else if (cmd_i.div_step) begin
        if (step_last) begin
          step_cnt_q <= '0;
          cnt_q      <= cnt_q + CNT_W'(1);
          rd_idx_q   <= cnt_q[IDX_W-1:0];
        end else begin
          step_cnt_q <= step_cnt_q + STEP_W'(1);
        end
      end else if (cmd_i.emit) begin
        rd_idx_q <= rd_idx_q - IDX_W'(1);
      end

      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers and the digit store.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      quot_q  <= PAD_W'(value_i[VALUE_USE_W-1:0]);
      rem_q   <= '0;
      radix_q <= radix_sat;
    end else if (cmd_i.div_step) begin
      quot_q <= quot_next;
      if (step_last) begin
        rem_q                            <= '0;
        digit_store[cnt_q[IDX_W-1:0]]    <= rem_next[RADIX_W-1:0];
      end else begin
        rem_q <= rem_next;
      end
    end
    if (cmd_i.emit) begin
      digit_char_q <= digit_to_ascii(digit_store[rd_idx_q]);
      last_digit_q <= (rd_idx_q == '0);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = digit_char_q;
  assign last_digit_o = last_digit_q;

  // A new digit never overwrites one that the consumer has not yet taken.
  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("digit loaded over an untaken digit");

  // After every division step the running remainder stays below the radix.
  a_rem_below_radix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.div_step) |-> (rem_q < {1'b0, radix_q}))
    else $error("remainder not below radix");

  // The digit count never runs past the store depth.
  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(VALUE_WIDTH))
    else $error("digit count past store depth");

  // Division and readout never overlap.
  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.div_step && (cmd_i.emit || cmd_i.load)))
    else $error("divide command overlaps another command");

endmodule

FILE: hdl/radix_ascii_converter_unit.sv
// ----------------------------------------------------------------------------
// Radix ASCII converter
// Converts an unsigned value to ASCII digits in radix 2 to 36, most
// significant digit first, flagging the final digit.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                      Transaction
//   in_i      sink       value[31:0], radix[5:0]      one conversion request
//   out_o     source     digit_char[6:0], last_digit  one ASCII digit
//
// Each digit costs one full division at 8 quotient bits per cycle, so an
// item with n digits holds the divider for n divisions and then streams
// its n digits out at one per cycle while the output is not stalled.
// The next request is taken once the final digit is in the output register.
// Reset is asynchronous and active low; no clearing pass is needed.
// A stalled output holds the current digit and pauses the readout.
//
module radix_ascii_converter_unit
  import rac_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  rac_in_if.sink    in_i,
  rac_out_if.source out_o
);

  rac_cmd_t cmd;
  rac_sts_t sts;

  // The controller walks through capture, one division per digit, and
  // readout of the stored remainders from the most significant end.
  rac_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the divider, the remainder store and the output
  // register, which decouples the digit consumer from the readout.
  rac_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .value_i      (in_i.value),
    .radix_i      (in_i.radix),
    .out_ready_i  (out_o.ready),
    .sts_o        (sts),
    .out_valid_o  (out_o.valid),
    .digit_char_o (out_o.digit_char),
    .last_digit_o (out_o.last_digit)
  );

endmodule

FILE: tb/radix_ascii_converter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix ASCII converter testbench
// Sends conversion requests over the request channel and checks every digit
// on the output channel against a digit string predicted inside this bench.
// Directed corner cases come first, then random traffic with bursty requests
// and a receiver that stalls on its own pattern.
// ----------------------------------------------------------------------------
module radix_ascii_converter_unit_tb;
  import rac_pkg::*;

  // The slowest conversion is 32 binary digits, and each digit can also sit
  // behind a receiver stall of random length. The limit below holds for all
  // items together with room to spare.
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  // Quiet time after the last digit, which is enough to catch a stray
  // digit that the block should not have produced.
  localparam int unsigned SETTLE_CYCLES = 200;

  // Digit characters in order of value, so that the predictor can look up
  // the ASCII code of each remainder.
  localparam string DIGIT_CHARS = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

  // One expected digit on the output channel.
  typedef struct {
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;
  } digit_t;

  logic clk_i;
  logic rst_ni;

  rac_in_if  req_if ();
  rac_out_if dig_if ();

  radix_ascii_converter_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (dig_if)
  );

  // Digits that the block still owes, oldest first.
  digit_t      digits_due[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  // Percentage of cycles on which the receiver begins a stall; zero means
  // the receiver is always ready.
  int unsigned stall_pct;

  // --------------------------------------------------------------------------
  // Clock and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // A run that hangs ends here with the failure line.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("%0t: timeout with %0d digits still expected", $time, digits_due.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Digit string predictor
  // --------------------------------------------------------------------------
  // Works out the digit string of one request and appends it to the queue of
  // digits the block owes. A radix outside 2 to 36 is clamped to the nearest
  // end of the range, and value bits above VALUE_WIDTH take no part. The
  // remainders come out least significant first, so they are read back in
  // reverse, and the final (least significant) digit carries the last flag.
  function automatic void predict_digit_string(input logic [VALUE_FIELD_W-1:0] value,
                                               input logic [RADIX_W-1:0]       radix);
    logic [63:0]  quot;
    int unsigned  base;
    int unsigned  rems[VALUE_WIDTH];
    int unsigned  n;
    digit_t       dig;

    base = radix;
    if (base < 2) begin
      base = 2;
    end else if (base > 36) begin
      base = 36;
    end
    quot = 64'(value) & ((64'd1 << VALUE_USE_W) - 64'd1);
    n    = 0;
    if (quot == 0) begin
      rems[0] = 0;
      n = 1;
    end else begin
      while (quot != 0 && n < VALUE_WIDTH) begin
        rems[n] = int'(quot % base);
        quot    = quot / base;
        n++;
      end
    end
    for (int unsigned k = 0; k < n; k++) begin
      dig.digit_char = CHAR_W'(DIGIT_CHARS[rems[n - 1 - k]]);
      dig.last_digit = (k == n - 1);
      digits_due.push_back(dig);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: ready with stalls of random length that start at random
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall_left;
    stall_left   = 0;
    dig_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        dig_if.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 11);
        dig_if.ready <= 1'b0;
      end else begin
        dig_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Digit checker: each transaction on the output channel is compared with
  // the oldest digit still owed.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    digit_t want;
    if (rst_ni && dig_if.valid && dig_if.ready) begin
      if (digits_due.size() == 0) begin
        $display("%0t: unexpected digit char=0x%02h last=%0b", $time,
                 dig_if.digit_char, dig_if.last_digit);
        mismatch_count++;
      end else begin
        want = digits_due.pop_front();
        if (dig_if.digit_char !== want.digit_char) begin
          $display("%0t: digit_char mismatch expected=0x%02h actual=0x%02h", $time,
                   want.digit_char, dig_if.digit_char);
          mismatch_count++;
        end
        if (dig_if.last_digit !== want.last_digit) begin
          $display("%0t: last_digit mismatch expected=%0b actual=%0b", $time,
                   want.last_digit, dig_if.last_digit);
          mismatch_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender helpers
  // --------------------------------------------------------------------------
  // Presents one request and waits for its transaction. Valid stays high on
  // return so that the next request can follow back to back; the digits are
  // queued at acceptance, long before the first one can appear.
  task automatic send_request(input logic [VALUE_FIELD_W-1:0] value,
                              input logic [RADIX_W-1:0]       radix);
    req_if.valid <= 1'b1;
    req_if.value <= value;
    req_if.radix <= radix;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    predict_digit_string(value, radix);
  endtask

  // Drops valid and keeps the channel quiet for a number of cycles.
  task automatic hold_off(input int unsigned cycles);
    if (cycles > 0) begin
      req_if.valid <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Waits until every owed digit has arrived.
  task automatic wait_for_digits;
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (digits_due.size() != 0) @(posedge clk_i);
  endtask

  // A value whose magnitude is spread evenly over the bit lengths, so short
  // and long digit strings are both common, with all-ones and zero mixed in.
  function automatic logic [VALUE_FIELD_W-1:0] random_value;
    int unsigned bits;
    int unsigned pick;
    pick = $urandom_range(0, 15);
    bits = $urandom_range(1, VALUE_FIELD_W);
    if (pick == 0) begin
      return '0;
    end else if (pick == 1) begin
      return '1;
    end
    return VALUE_FIELD_W'($urandom & ((64'd1 << bits) - 64'd1));
  endfunction

  // Mostly a legal radix, sometimes one that the block must clamp.
  function automatic logic [RADIX_W-1:0] random_radix;
    if ($urandom_range(0, 99) < 85) begin
      return RADIX_W'($urandom_range(2, 36));
    end
    return RADIX_W'($urandom_range(0, 63));
  endfunction

  // Sends random requests in bursts of random length. Between bursts the
  // sender pauses for a random gap bounded by max_gap, but now and then it goes
  // straight on so that long stretches without gaps occur too.
  task automatic send_bursts(input int unsigned count, input int unsigned max_gap);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 8);
      for (int unsigned i = 0; i < burst && sent < count; i++) begin
        send_request(random_value(), random_radix());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        hold_off($urandom_range(1, max_gap));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Corner cases: zero, all ones, the widest and narrowest radix, each
  // radix that is clamped from below or above, the single letter digits,
  // and the carry into a second digit.
  task automatic test_corner_values;
    stall_pct = 0;
    send_request(32'h0000_0000, 6'd10);
    send_request(32'h0000_0000, 6'd2);
    send_request(32'h0000_0000, 6'd36);
    send_request(32'hFFFF_FFFF, 6'd2);
    send_request(32'hFFFF_FFFF, 6'd36);
    send_request(32'hFFFF_FFFF, 6'd16);
    send_request(32'hFFFF_FFFF, 6'd10);
    send_request(32'h8000_0000, 6'd2);
    send_request(32'h0000_0001, 6'd2);
    send_request(32'h0000_0009, 6'd10);
    send_request(32'h0000_000A, 6'd16);
    send_request(32'h0000_0023, 6'd36);
    send_request(32'h0000_0024, 6'd36);
    send_request(32'h0000_00FF, 6'd8);
    send_request(32'hDEAD_BEEF, 6'd32);
    // Radix values below two act as binary, those above 36 as radix 36.
    send_request(32'h0000_3039, 6'd0);
    send_request(32'h0000_3039, 6'd1);
    send_request(32'h0000_3039, 6'd37);
    send_request(32'h0000_3039, 6'd63);
    send_request(32'h0000_0001, 6'd63);
    wait_for_digits();
  endtask

  // The bulk of the random traffic, with the receiver stalling often.
  task automatic test_random_conversions;
    stall_pct = 25;
    send_bursts(150, 6);
    wait_for_digits();
  endtask

  // Single-digit results back to back with an always-ready receiver, which
  // keeps the turnaround between requests as short as the block allows.
  // A value below the effective radix always gives exactly one digit.
  task automatic test_single_digit_turnaround;
    logic [RADIX_W-1:0] radix;
    int unsigned        base;
    stall_pct = 0;
    for (int i = 0; i < 30; i++) begin
      radix = random_radix();
      base  = (radix < RADIX_MIN) ? 2 : ((radix > RADIX_MAX) ? 36 : int'(radix));
      send_request(VALUE_FIELD_W'($urandom_range(0, base - 1)), radix);
    end
    wait_for_digits();
  endtask

  // Long strings in small radixes, with a receiver that stalls heavily so
  // the readout pauses on many different digits.
  task automatic test_long_strings;
    stall_pct = 50;
    for (int i = 0; i < 30; i++) begin
      send_request(random_value() | 32'h8000_0000, RADIX_W'($urandom_range(0, 4)));
      if ($urandom_range(0, 1) == 1) begin
        hold_off($urandom_range(1, 4));
      end
    end
    wait_for_digits();
  endtask

  // The sender waits for every digit owed after each group of bursts, so that
  // requests also arrive at a block that has gone fully idle.
  task automatic test_drain_between_bursts;
    stall_pct = 10;
    for (int i = 0; i < 10; i++) begin
      send_bursts($urandom_range(3, 6), 3);
      wait_for_digits();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    mismatch_count = 0;
    stall_pct      = 0;
    req_if.valid   = 1'b0;
    req_if.value   = '0;
    req_if.radix   = '0;
    rst_ni         = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_values();
    test_random_conversions();
    test_single_digit_turnaround();
    test_long_strings();
    test_drain_between_bursts();

    // Everything has been accepted and received; leave time for any stray
    // digit to show up before the verdict.
    req_if.valid <= 1'b0;
    while (digits_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/rac_pkg.sv
hdl/rac_ifs.sv
hdl/rac_ctrl.sv
hdl/rac_dpath.sv
hdl/radix_ascii_converter_unit.sv
tb/radix_ascii_converter_unit_tb.sv
